[rtl/mef_pkg.sv]
// Shared constants and types for the multichannel EMA filter.
`timescale 1ns / 1ps
package mef_pkg;

  localparam int NUM_CHANNELS        = 7;
  localparam int NUM_OFFSET_CHANNELS = 3;
  localparam int SAMPLE_BITS_DEF     = 12;
  localparam int FRAC_BITS           = 16;
  localparam int ALPHA_BITS          = 16;
  localparam int CFG_IDX_BITS        = 2;

  localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = 16'd6554;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ALPHA_CURRENT = 2'd0,
    CFG_ALPHA_TEMP    = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic step;
    logic capture;
  } lane_ctrl_t;

endpackage

[rtl/mef_lane.sv]
// One filter lane: Q.16 accumulator, registered update and offset capture.
`timescale 1ns / 1ps
module mef_lane
  import mef_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter bit HAS_OFFSET  = 1'b0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lane_ctrl_t                    ctrl,
  input  logic [ALPHA_BITS-1:0]         alpha,
  input  logic [SAMPLE_BITS-1:0]        sample,
  output logic signed [SAMPLE_BITS:0]   filt
);

  localparam int ACC_W  = SAMPLE_BITS + FRAC_BITS;
  localparam int PROD_W = SAMPLE_BITS + ALPHA_BITS + 2;

  logic [ACC_W-1:0]          acc_r, acc_nxt;
  logic [SAMPLE_BITS-1:0]    offset_r, offset_nxt;
  logic [SAMPLE_BITS-1:0]    acc_floor;
  logic signed [SAMPLE_BITS:0] diff;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  sum;

  assign acc_floor = acc_r[ACC_W-1 -: SAMPLE_BITS];
  assign diff = $signed({1'b0, sample}) - $signed({1'b0, acc_floor});
  assign prod = PROD_W'(diff) * $signed({{(PROD_W-ALPHA_BITS){1'b0}}, alpha});
  assign sum  = $signed({{(PROD_W-ACC_W){1'b0}}, acc_r}) + prod;

  always_comb begin
    acc_nxt    = acc_r;
    offset_nxt = offset_r;
    if (ctrl.step) begin
      if (sum[PROD_W-1]) begin
        acc_nxt = '0;
      end else if (|sum[PROD_W-2:ACC_W]) begin
        acc_nxt = '1;
      end else begin
        acc_nxt = sum[ACC_W-1:0];
      end
    end
    if (ctrl.capture) begin
      offset_nxt = HAS_OFFSET ? acc_floor : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      offset_r <= '0;
    end else begin
      acc_r    <= acc_nxt;
      offset_r <= offset_nxt;
    end
  end

  assign filt = $signed({1'b0, acc_floor}) - $signed({1'b0, offset_r});

endmodule

[rtl/mef_merge.sv]
// Output stage: result beat valid, handshake and lane step control.
`timescale 1ns / 1ps
module mef_merge
  import mef_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_command,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output lane_ctrl_t ctrl
);

  logic out_valid_r, out_valid_nxt;
  logic accept;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign ctrl.step    = accept && !in_command;
  assign ctrl.capture = accept && in_command;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[rtl/multichannel_ema_filter_with_offset.sv]
// Top level of the multichannel EMA filter with offset capture.
//
// Input channel (in_valid/in_ready): one beat is a scan of seven ADC samples
// plus a command bit. Command 0 filters the scan, each lane updating
// acc += alpha * (sample - floor(acc)) in Q.16; command 1 ignores the samples
// and latches floor(acc) of channels 0-2 as their offsets.
// Result channel (out_valid/out_ready): one beat per input beat carrying
// floor(acc) per channel, channels 0-2 less their offsets (signed).
// Configuration channel (cfg_valid/cfg_ready): index 0 alpha_current,
// index 1 alpha_temp; cfg_ready is always high; other indexes are dropped.
// The result beat appears in the cycle after its input beat is taken.
// Throughput is one beat per cycle while the receiver does not stall, set
// by the per-lane multiply-accumulate loop on the accumulator register.
// Reset clears accumulators and offsets and restores both alphas to 6554.
// When the receiver stalls, the result holds and in_ready drops until the
// pending beat is taken; in_ready rises again in the cycle it is taken.
`timescale 1ns / 1ps
module multichannel_ema_filter_with_offset
  import mef_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [ALPHA_BITS-1:0]        cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_command,
  input  logic [SAMPLE_BITS-1:0]       in_sample_ch0,
  input  logic [SAMPLE_BITS-1:0]       in_sample_ch1,
  input  logic [SAMPLE_BITS-1:0]       in_sample_ch2,
  input  logic [SAMPLE_BITS-1:0]       in_sample_ch3,
  input  logic [SAMPLE_BITS-1:0]       in_sample_ch4,
  input  logic [SAMPLE_BITS-1:0]       in_sample_ch5,
  input  logic [SAMPLE_BITS-1:0]       in_sample_ch6,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [SAMPLE_BITS:0]  out_filtered_ch0,
  output logic signed [SAMPLE_BITS:0]  out_filtered_ch1,
  output logic signed [SAMPLE_BITS:0]  out_filtered_ch2,
  output logic [SAMPLE_BITS-1:0]       out_filtered_ch3,
  output logic [SAMPLE_BITS-1:0]       out_filtered_ch4,
  output logic [SAMPLE_BITS-1:0]       out_filtered_ch5,
  output logic [SAMPLE_BITS-1:0]       out_filtered_ch6
);

  logic [ALPHA_BITS-1:0]      alpha_current_r, alpha_current_nxt;
  logic [ALPHA_BITS-1:0]      alpha_temp_r, alpha_temp_nxt;
  logic [SAMPLE_BITS-1:0]     samples [NUM_CHANNELS];
  logic signed [SAMPLE_BITS:0] lane_filt [NUM_CHANNELS];
  lane_ctrl_t                 ctrl;

  assign cfg_ready = 1'b1;

  always_comb begin
    alpha_current_nxt = alpha_current_r;
    alpha_temp_nxt    = alpha_temp_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ALPHA_CURRENT: alpha_current_nxt = cfg_data;
        CFG_ALPHA_TEMP:    alpha_temp_nxt    = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_current_r <= ALPHA_RESET;
      alpha_temp_r    <= ALPHA_RESET;
    end else begin
      alpha_current_r <= alpha_current_nxt;
      alpha_temp_r    <= alpha_temp_nxt;
    end
  end

  assign samples[0] = in_sample_ch0;
  assign samples[1] = in_sample_ch1;
  assign samples[2] = in_sample_ch2;
  assign samples[3] = in_sample_ch3;
  assign samples[4] = in_sample_ch4;
  assign samples[5] = in_sample_ch5;
  assign samples[6] = in_sample_ch6;

  mef_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ctrl       (ctrl)
  );

  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_lane
    localparam bit IS_OFS = (i < NUM_OFFSET_CHANNELS);
    mef_lane #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .HAS_OFFSET  (IS_OFS)
    ) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (ctrl),
      .alpha  (IS_OFS ? alpha_current_r : alpha_temp_r),
      .sample (samples[i]),
      .filt   (lane_filt[i])
    );
  end

  assign out_filtered_ch0 = lane_filt[0];
  assign out_filtered_ch1 = lane_filt[1];
  assign out_filtered_ch2 = lane_filt[2];
  assign out_filtered_ch3 = lane_filt[3][SAMPLE_BITS-1:0];
  assign out_filtered_ch4 = lane_filt[4][SAMPLE_BITS-1:0];
  assign out_filtered_ch5 = lane_filt[5][SAMPLE_BITS-1:0];
  assign out_filtered_ch6 = lane_filt[6][SAMPLE_BITS-1:0];

endmodule

[rtl/mef_checker.sv]
// Port-level checks for the multichannel EMA filter, bound to the top level.
`timescale 1ns / 1ps
module mef_checker
  import mef_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_command,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic signed [SAMPLE_BITS:0] out_filtered_ch0,
  input logic signed [SAMPLE_BITS:0] out_filtered_ch1,
  input logic signed [SAMPLE_BITS:0] out_filtered_ch2,
  input logic [SAMPLE_BITS-1:0]      out_filtered_ch3
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_filtered_ch0)
      && $stable(out_filtered_ch3))
    else $error("result beat changed while stalled");

  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result beat stalled");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("no result beat one cycle after input beat");

  a_capture_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command |=>
      out_filtered_ch0 == '0 && out_filtered_ch1 == '0 && out_filtered_ch2 == '0)
    else $error("offset channels not zero after capture");

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input not ready with empty output stage");

endmodule

bind multichannel_ema_filter_with_offset mef_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_mef_checker (.*);

[tb/multichannel_ema_filter_with_offset_tb.sv]
// Self-checking bench for the multichannel EMA filter: directed table, then random scans.
`timescale 1ns / 1ps
module multichannel_ema_filter_with_offset_tb;
  import mef_pkg::*;

  localparam int SB = SAMPLE_BITS_DEF;
  localparam int LIMIT_CYCLES = 200000;
  localparam int PHASES = 13;
  localparam int SCANS_PER_PHASE = 100;
  localparam longint ACC_MAX = (longint'(1) << (SB + FRAC_BITS)) - 1;

  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_CAPTURE = 1'b1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 2'd3;

  typedef logic [NUM_CHANNELS-1:0][SB-1:0] sample_set_t;
  typedef logic [NUM_CHANNELS-1:0][SB:0] scan_out_t;

  typedef struct packed {
    logic command;
    sample_set_t sample;
  } scan_t;

  typedef enum logic {ROW_SCAN, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    logic [CFG_IDX_BITS-1:0] idx;
    logic [ALPHA_BITS-1:0] data;
    scan_t scan;
    logic known;
    scan_out_t result;
  } plan_row_t;

  localparam sample_set_t ALL_HI = {NUM_CHANNELS{12'hFFF}};
  localparam sample_set_t ALL_LO = '0;
  localparam sample_set_t CHK_A = {{3{12'hAAA, 12'h555}}, 12'hAAA};
  localparam sample_set_t CHK_B = {{3{12'h555, 12'hAAA}}, 12'h555};
  localparam sample_set_t MID_HI = {NUM_CHANNELS{12'h800}};
  localparam sample_set_t MID_LO = {NUM_CHANNELS{12'h7FF}};
  localparam sample_set_t LSB_ONLY = {NUM_CHANNELS{12'h001}};
  localparam scan_out_t DEEP_NEG = {{4{13'h0000}}, {3{13'h1001}}};

  localparam int PLAN_ROWS = 24;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{ROW_SCAN, CFG_ALPHA_CURRENT, 16'd0, {CMD_CAPTURE, ALL_HI}, 1'b1, '0},
    '{ROW_SCAN, CFG_ALPHA_CURRENT, 16'd0, {CMD_FILTER, ALL_LO}, 1'b1, '0},
    '{ROW_CFG, CFG_ALPHA_CURRENT, 16'hFFFF, '0, 1'b0, '0},
    '{ROW_CFG, CFG_ALPHA_TEMP, 16'hFFFF, '0, 1'b0, '0},
    '{ROW_SCAN, CFG_ALPHA_CURRENT, 16'd0, {CMD_FILTER, ALL_HI}, 1'b0, '0},
    '{ROW_SCAN, CFG_ALPHA_CURRENT, 16'd0, {CMD_FILTER, ALL_HI}, 1'b0, '0},
    '{ROW_SCAN, CFG_ALPHA_CURRENT, 16'd0, {CMD_CAPTURE, ALL_LO}, 1'b0, '0},
    '{ROW_SCAN, CFG_ALPHA_CURRENT, 16'd0, {CMD_FILTER, ALL_LO}, 1'b1, DEEP_NEG},
    '{ROW_SCAN, CFG_ALPHA_CURRENT, 16'd0, {CMD_FILTER, ALL_HI}, 1'b0, '0},
    '{ROW_CFG, CFG_ALPHA_CURRENT, 16'h0000, '0, 1'b0, '0},
    '{ROW_CFG, CFG_ALPHA_TEMP, 16'h0000, '0, 1'b0, '0},
    '{ROW_SCAN, CFG_ALPHA_CURRENT, 16'd0, {CMD_FILTER, CHK_A}, 1'b0, '0},
    '{ROW_SCAN, CFG_ALPHA_CURRENT, 16'd0, {CMD_CAPTURE, CHK_B}, 1'b0, '0},
    '{ROW_CFG, CFG_SPARE_LO, 16'hFFFF, '0, 1'b0, '0},
    '{ROW_CFG, CFG_SPARE_HI, 16'h1234, '0, 1'b0, '0},
    '{ROW_CFG, CFG_ALPHA_CURRENT, 16'h0001, '0, 1'b0, '0},
    '{ROW_CFG, CFG_ALPHA_TEMP, 16'h8000, '0, 1'b0, '0},
    '{ROW_SCAN, CFG_ALPHA_CURRENT, 16'd0, {CMD_FILTER, CHK_B}, 1'b0, '0},
    '{ROW_SCAN, CFG_ALPHA_CURRENT, 16'd0, {CMD_FILTER, ALL_HI}, 1'b0, '0},
    '{ROW_CFG, CFG_ALPHA_CURRENT, ALPHA_RESET, '0, 1'b0, '0},
    '{ROW_CFG, CFG_ALPHA_TEMP, ALPHA_RESET, '0, 1'b0, '0},
    '{ROW_SCAN, CFG_ALPHA_CURRENT, 16'd0, {CMD_FILTER, MID_HI}, 1'b0, '0},
    '{ROW_SCAN, CFG_ALPHA_CURRENT, 16'd0, {CMD_CAPTURE, MID_LO}, 1'b0, '0},
    '{ROW_SCAN, CFG_ALPHA_CURRENT, 16'd0, {CMD_FILTER, LSB_ONLY}, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [ALPHA_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_command = 1'b0;
  logic [SB-1:0] in_sample_ch0 = '0;
  logic [SB-1:0] in_sample_ch1 = '0;
  logic [SB-1:0] in_sample_ch2 = '0;
  logic [SB-1:0] in_sample_ch3 = '0;
  logic [SB-1:0] in_sample_ch4 = '0;
  logic [SB-1:0] in_sample_ch5 = '0;
  logic [SB-1:0] in_sample_ch6 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SB:0] out_filtered_ch0;
  logic signed [SB:0] out_filtered_ch1;
  logic signed [SB:0] out_filtered_ch2;
  logic [SB-1:0] out_filtered_ch3;
  logic [SB-1:0] out_filtered_ch4;
  logic [SB-1:0] out_filtered_ch5;
  logic [SB-1:0] out_filtered_ch6;

  logic steady = 1'b0;
  int fault_count = 0;

  longint acc_q [NUM_CHANNELS] = '{default: 0};
  logic [SB-1:0] offset_q [NUM_OFFSET_CHANNELS] = '{default: '0};
  logic [ALPHA_BITS-1:0] alpha_cur = ALPHA_RESET;
  logic [ALPHA_BITS-1:0] alpha_tmp = ALPHA_RESET;
  scan_out_t pending_outputs [$];

  multichannel_ema_filter_with_offset DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_sample_ch0    (in_sample_ch0),
    .in_sample_ch1    (in_sample_ch1),
    .in_sample_ch2    (in_sample_ch2),
    .in_sample_ch3    (in_sample_ch3),
    .in_sample_ch4    (in_sample_ch4),
    .in_sample_ch5    (in_sample_ch5),
    .in_sample_ch6    (in_sample_ch6),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_filtered_ch0 (out_filtered_ch0),
    .out_filtered_ch1 (out_filtered_ch1),
    .out_filtered_ch2 (out_filtered_ch2),
    .out_filtered_ch3 (out_filtered_ch3),
    .out_filtered_ch4 (out_filtered_ch4),
    .out_filtered_ch5 (out_filtered_ch5),
    .out_filtered_ch6 (out_filtered_ch6)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic scan_out_t ema_predict(input scan_t s);
    scan_out_t r;
    longint whole;
    longint nxt;
    longint gain;
    for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
      whole = acc_q[ch] >>> FRAC_BITS;
      if (s.command == CMD_CAPTURE) begin
        if (ch < NUM_OFFSET_CHANNELS) offset_q[ch] = whole[SB-1:0];
      end else begin
        if (ch < NUM_OFFSET_CHANNELS) gain = longint'(alpha_cur);
        else gain = longint'(alpha_tmp);
        nxt = acc_q[ch] + gain * (longint'(s.sample[ch]) - whole);
        if (nxt < 0) nxt = 0;
        if (nxt > ACC_MAX) nxt = ACC_MAX;
        acc_q[ch] = nxt;
      end
      whole = acc_q[ch] >>> FRAC_BITS;
      if (ch < NUM_OFFSET_CHANNELS) r[ch] = (SB+1)'(whole - longint'(offset_q[ch]));
      else r[ch] = {1'b0, whole[SB-1:0]};
    end
    return r;
  endfunction

  function automatic logic [ALPHA_BITS-1:0] pick_alpha();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return 16'd1;
      default: return ALPHA_BITS'($urandom_range(65535));
    endcase
  endfunction

  task automatic push_scan(input scan_t s, input logic known, input scan_out_t typed);
    scan_out_t want;
    if (!steady) begin
      while ($urandom_range(99) < 24) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_command <= s.command;
    {in_sample_ch6, in_sample_ch5, in_sample_ch4, in_sample_ch3,
     in_sample_ch2, in_sample_ch1, in_sample_ch0} <= s.sample;
    do @(posedge clk); while (!in_ready);
    want = ema_predict(s);
    pending_outputs.push_back(known ? typed : want);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [ALPHA_BITS-1:0] val);
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ALPHA_CURRENT: alpha_cur = val;
      CFG_ALPHA_TEMP: alpha_tmp = val;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch_out
    scan_out_t got;
    scan_out_t want;
    if (rst_n && out_valid && out_ready) begin
      got[0] = out_filtered_ch0;
      got[1] = out_filtered_ch1;
      got[2] = out_filtered_ch2;
      got[3] = {1'b0, out_filtered_ch3};
      got[4] = {1'b0, out_filtered_ch4};
      got[5] = {1'b0, out_filtered_ch5};
      got[6] = {1'b0, out_filtered_ch6};
      if (pending_outputs.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) $display("result beat with nothing expected at %0t", $time);
      end else begin
        want = pending_outputs.pop_front();
        for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
          if (got[ch] !== want[ch]) begin
            fault_count++;
            if (fault_count <= 10)
              $display("filtered_ch%0d at %0t: expected 0x%h, got 0x%h",
                       ch, $time, want[ch], got[ch]);
          end
        end
      end
    end
    out_ready <= steady || ($urandom_range(99) >= 24);
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  initial begin
    scan_t s;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (PLAN[i].kind == ROW_CFG) write_reg(PLAN[i].idx, PLAN[i].data);
      else push_scan(PLAN[i].scan, PLAN[i].known, PLAN[i].result);
    end

    for (int p = 0; p < PHASES; p++) begin
      write_reg(CFG_ALPHA_CURRENT, pick_alpha());
      write_reg(CFG_ALPHA_TEMP, pick_alpha());
      if ($urandom_range(3) == 0)
        write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, ALPHA_BITS'($urandom));
      steady <= (p == PHASES / 2);
      repeat (SCANS_PER_PHASE) begin
        s.command = ($urandom_range(7) == 0) ? CMD_CAPTURE : CMD_FILTER;
        for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
          case ($urandom_range(9))
            0: s.sample[ch] = '0;
            1: s.sample[ch] = '1;
            2, 3: s.sample[ch] = SB'((acc_q[ch] >>> FRAC_BITS) + $urandom_range(8) - 4);
            default: s.sample[ch] = SB'($urandom_range(4095));
          endcase
        end
        push_scan(s, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    steady <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fault_count == 0 && pending_outputs.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
